/* hdl/lav_pkg.sv */
// Shared types, constants and rounding helpers for the look-at view matrix core.
`default_nettype none

package lav_pkg;

  localparam int AxisFrac = 30;

  localparam logic signed [31:0] AxisOne    = 32'sd1073741824;
  localparam logic signed [31:0] AxisNegOne = -32'sd1073741824;
  localparam logic signed [63:0] AxisOne64  = 64'sd1073741824;
  localparam logic signed [63:0] Int32Max64 = 64'sd2147483647;
  localparam logic signed [63:0] Int32Min64 = -64'sd2147483648;
  localparam logic signed [31:0] Int32Max   = 32'sh7fffffff;
  localparam logic signed [31:0] Int32Min   = 32'sh80000000;

  typedef enum logic [1:0] {
    ROW_U = 2'd0,
    ROW_V = 2'd1,
    ROW_W = 2'd2
  } row_e;

  // flags that travel with an item between pipeline blocks
  typedef struct packed {
    logic valid;
    logic ok;
  } lav_ctl_t;

  // shift right by AxisFrac, rounding half away from zero
  function automatic logic signed [63:0] round_q30(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r   = (mag + (64'd1 << (AxisFrac - 1))) >> AxisFrac;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] clamp_axis(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = round_q30(x);
    if (r > AxisOne64) begin
      return AxisOne;
    end else if (r < -AxisOne64) begin
      return AxisNegOne;
    end
    return r[31:0];
  endfunction

  // negated, rounded and saturated offset
  function automatic logic signed [31:0] neg_sat(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = -round_q30(x);
    if (r > Int32Max64) begin
      return Int32Max;
    end else if (r < Int32Min64) begin
      return Int32Min;
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/lav_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module lav_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [61:0]   n_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [30:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int NS = 32;

  logic          v_q    [NS];
  logic [63:0]   n_q    [NS];
  logic [63:0]   res_q  [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int Sh = 62 - 2 * k;
    logic          v_in;
    logic [63:0]   n_in;
    logic [63:0]   res_in;
    logic [SW-1:0] side_in;
    logic [63:0]   bit_w;
    logic [63:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = 64'(n_i);
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign n_in    = n_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign bit_w = 64'd1 << Sh;
    assign trial = res_in + bit_w;
    assign ge    = n_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= ge ? n_in - trial : n_in;
        res_q[k]  <= ge ? (res_in >> 1) + bit_w : res_in >> 1;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign root_o  = res_q[NS-1][30:0];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

/* hdl/lav_div.sv */
// Pipelined restoring divider: three numerators over one divisor, one quotient bit per stage.
`default_nettype none

module lav_div #(
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2:0][60:0] num_i,
  input  logic [30:0]      den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [2:0][30:0] quo_o,
  output logic [SW-1:0]    side_o
);

  localparam int NS = 31;

  logic             v_q    [NS];
  logic [2:0][60:0] rem_q  [NS];
  logic [2:0][30:0] quo_q  [NS];
  logic [30:0]      den_q  [NS];
  logic [SW-1:0]    side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int Sh = NS - 1 - k;
    logic             v_in;
    logic [2:0][60:0] rem_in;
    logic [2:0][30:0] quo_in;
    logic [30:0]      den_in;
    logic [SW-1:0]    side_in;
    logic [61:0]      dsh;
    logic [2:0][60:0] rem_nx;
    logic [2:0][30:0] quo_nx;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = 62'(den_in) << Sh;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        quo_nx[j] = quo_in[j];
        if ({1'b0, rem_in[j]} >= dsh) begin
          rem_nx[j]     = 61'({1'b0, rem_in[j]} - dsh);
          quo_nx[j][Sh] = 1'b1;
        end else begin
          rem_nx[j] = rem_in[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        quo_q[k]  <= quo_nx;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

/* hdl/lav_norm.sv */
// Vector normalization pipeline: scale to a fixed exponent, root of the sum of squares, divide.
`default_nettype none

module lav_norm #(
  parameter int IW = 33,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][IW-1:0]   vec_i,
  input  logic [SW-1:0]        side_i,
  output lav_pkg::lav_ctl_t    ctl_o,
  output logic [2:0][31:0]     vec_o,
  output logic [SW-1:0]        side_o
);
  import lav_pkg::*;

  localparam int NCH = (IW + 7) / 8;
  localparam int PW  = $clog2(NCH * 8);
  localparam int RW  = SW + 94;   // side, signs, scaled magnitudes, zero flag
  localparam int DW  = SW + 4;    // side, signs, zero flag

  // stage 1: magnitudes and their OR
  logic                 s1_v_q;
  logic [2:0][IW-1:0]   s1_mag_q;
  logic [2:0]           s1_neg_q;
  logic [IW-1:0]        s1_or_q;
  logic [SW-1:0]        s1_side_q;
  logic [2:0][IW-1:0]   s1_mag_d;
  logic [2:0]           s1_neg_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s1_neg_d[j] = vec_i[j][IW-1];
      s1_mag_d[j] = vec_i[j][IW-1] ? IW'(-$signed(vec_i[j])) : vec_i[j];
    end
  end

  // stage 2: per-byte leading one
  logic                 s2_v_q;
  logic [2:0][IW-1:0]   s2_mag_q;
  logic [2:0]           s2_neg_q;
  logic [SW-1:0]        s2_side_q;
  logic [NCH-1:0]       s2_nz_q;
  logic [2:0]           s2_pos_q [NCH];
  logic [NCH-1:0]       s2_nz_d;
  logic [2:0]           s2_pos_d [NCH];
  logic [NCH*8-1:0]     orp;

  assign orp = (NCH * 8)'(s1_or_q);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      s2_nz_d[c]  = |orp[c*8 +: 8];
      s2_pos_d[c] = '0;
      for (int j = 0; j < 8; j++) begin
        if (orp[c*8 + j]) begin
          s2_pos_d[c] = 3'(j);
        end
      end
    end
  end

  // stage 3: leading one of the whole word
  logic                 s3_v_q;
  logic [2:0][IW-1:0]   s3_mag_q;
  logic [2:0]           s3_neg_q;
  logic [SW-1:0]        s3_side_q;
  logic [PW-1:0]        s3_p_q;
  logic                 s3_zero_q;
  logic [PW-1:0]        s3_p_d;
  logic                 s3_zero_d;

  always_comb begin
    s3_p_d    = '0;
    s3_zero_d = 1'b1;
    for (int c = 0; c < NCH; c++) begin
      if (s2_nz_q[c]) begin
        s3_p_d    = PW'(c * 8) + PW'(s2_pos_q[c]);
        s3_zero_d = 1'b0;
      end
    end
  end

  // stage 4: shift so the largest magnitude has its top bit at 29
  logic                 s4_v_q;
  logic [2:0][29:0]     s4_m_q;
  logic [2:0]           s4_neg_q;
  logic [SW-1:0]        s4_side_q;
  logic                 s4_zero_q;
  logic [2:0][29:0]     s4_m_d;
  logic [IW-1:0]        shr [3];
  logic [IW-1:0]        shl [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shr[j] = s3_mag_q[j] >> (s3_p_q - PW'(29));
      shl[j] = s3_mag_q[j] << (PW'(29) - s3_p_q);
      s4_m_d[j] = (s3_p_q >= PW'(29)) ? shr[j][29:0] : shl[j][29:0];
    end
  end

  // stage 5: squares
  logic                 s5_v_q;
  logic [2:0][29:0]     s5_m_q;
  logic [2:0][59:0]     s5_sq_q;
  logic [2:0]           s5_neg_q;
  logic [SW-1:0]        s5_side_q;
  logic                 s5_zero_q;

  // stage 6: sum of squares
  logic                 s6_v_q;
  logic [61:0]          s6_sum_q;
  logic [RW-1:0]        s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q  <= s1_mag_d;
      s1_neg_q  <= s1_neg_d;
      s1_or_q   <= s1_mag_d[0] | s1_mag_d[1] | s1_mag_d[2];
      s1_side_q <= side_i;

      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_side_q <= s1_side_q;
      s2_nz_q   <= s2_nz_d;
      s2_pos_q  <= s2_pos_d;

      s3_mag_q  <= s2_mag_q;
      s3_neg_q  <= s2_neg_q;
      s3_side_q <= s2_side_q;
      s3_p_q    <= s3_p_d;
      s3_zero_q <= s3_zero_d;

      s4_m_q    <= s4_m_d;
      s4_neg_q  <= s3_neg_q;
      s4_side_q <= s3_side_q;
      s4_zero_q <= s3_zero_q;

      for (int j = 0; j < 3; j++) begin
        s5_sq_q[j] <= 60'(s4_m_q[j]) * 60'(s4_m_q[j]);
      end
      s5_m_q    <= s4_m_q;
      s5_neg_q  <= s4_neg_q;
      s5_side_q <= s4_side_q;
      s5_zero_q <= s4_zero_q;

      s6_sum_q  <= 62'(s5_sq_q[0]) + 62'(s5_sq_q[1]) + 62'(s5_sq_q[2]);
      s6_side_q <= {s5_side_q, s5_neg_q, s5_m_q, s5_zero_q};
    end
  end

  logic           rt_v;
  logic [30:0]    rt_root;
  logic [RW-1:0]  rt_side;

  lav_isqrt #(.SW(RW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s6_v_q),
    .n_i     (s6_sum_q),
    .side_i  (s6_side_q),
    .valid_o (rt_v),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  logic [SW-1:0]     rt_side_o;
  logic [2:0]        rt_neg;
  logic [2:0][29:0]  rt_m;
  logic              rt_zero;

  assign {rt_side_o, rt_neg, rt_m, rt_zero} = rt_side;

  // stage 7: rounded numerators
  logic              s7_v_q;
  logic [2:0][60:0]  s7_num_q;
  logic [30:0]       s7_den_q;
  logic [DW-1:0]     s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en_i) begin
      s7_v_q <= rt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        s7_num_q[j] <= {1'b0, rt_m[j], 30'd0} + 61'(rt_root >> 1);
      end
      s7_den_q  <= rt_root;
      s7_side_q <= {rt_side_o, rt_neg, rt_zero};
    end
  end

  logic              dv_v;
  logic [2:0][30:0]  dv_quo;
  logic [DW-1:0]     dv_side;

  lav_div #(.SW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s7_v_q),
    .num_i   (s7_num_q),
    .den_i   (s7_den_q),
    .side_i  (s7_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  logic [SW-1:0] dv_side_o;
  logic [2:0]    dv_neg;
  logic          dv_zero;

  assign {dv_side_o, dv_neg, dv_zero} = dv_side;

  // stage 8: restore signs
  logic              s8_v_q;
  logic              s8_ok_q;
  logic [2:0][31:0]  s8_vec_q;
  logic [SW-1:0]     s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en_i) begin
      s8_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        s8_vec_q[j] <= dv_neg[j] ? -{1'b0, dv_quo[j]} : {1'b0, dv_quo[j]};
      end
      s8_ok_q   <= !dv_zero;
      s8_side_q <= dv_side_o;
    end
  end

  assign ctl_o.valid = s8_v_q;
  assign ctl_o.ok    = s8_ok_q;
  assign vec_o       = s8_vec_q;
  assign side_o      = s8_side_q;

endmodule

`default_nettype wire

/* hdl/lav_post.sv */
// Third axis and translation offsets for the three rows.
`default_nettype none

module lav_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  lav_pkg::lav_ctl_t   ctl_i,
  input  logic [2:0][31:0]    w_i,
  input  logic [2:0][31:0]    u_i,
  input  logic [2:0][31:0]    pos_i,
  output lav_pkg::lav_ctl_t   ctl_o,
  output logic [2:0][31:0]    u_o,
  output logic [2:0][31:0]    v_o,
  output logic [2:0][31:0]    w_o,
  output logic [2:0][31:0]    off_o
);
  import lav_pkg::*;

  logic [5:0] v_q;
  logic [5:0] ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], ctl_i.valid};
    end
  end

  // stage 1: products
  logic signed [63:0] t1_vp_q [6];
  logic signed [63:0] t1_pu_q [3];
  logic signed [63:0] t1_pw_q [3];
  logic [2:0][31:0]   t1_u_q, t1_w_q;
  // stage 2: differences and sums
  logic signed [63:0] t2_vd_q [3];
  logic signed [63:0] t2_su_q, t2_sw_q;
  logic [2:0][31:0]   t2_u_q, t2_w_q, t2_pos_q, t1_pos_q;
  // stage 3: rounded v, u and w offsets
  logic [2:0][31:0]   t3_u_q, t3_v_q, t3_w_q, t3_pos_q;
  logic [31:0]        t3_ou_q, t3_ow_q;
  // stage 4: v products
  logic signed [63:0] t4_pv_q [3];
  logic [2:0][31:0]   t4_u_q, t4_v_q, t4_w_q;
  logic [31:0]        t4_ou_q, t4_ow_q;
  // stage 5: v sum
  logic signed [63:0] t5_sv_q;
  logic [2:0][31:0]   t5_u_q, t5_v_q, t5_w_q;
  logic [31:0]        t5_ou_q, t5_ow_q;
  // stage 6: v offset
  logic [2:0][31:0]   t6_u_q, t6_v_q, t6_w_q;
  logic [31:0]        t6_ou_q, t6_ov_q, t6_ow_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= {ok_q[4:0], ctl_i.ok};

      t1_vp_q[0] <= $signed(w_i[1]) * $signed(u_i[2]);
      t1_vp_q[1] <= $signed(w_i[2]) * $signed(u_i[1]);
      t1_vp_q[2] <= $signed(w_i[2]) * $signed(u_i[0]);
      t1_vp_q[3] <= $signed(w_i[0]) * $signed(u_i[2]);
      t1_vp_q[4] <= $signed(w_i[0]) * $signed(u_i[1]);
      t1_vp_q[5] <= $signed(w_i[1]) * $signed(u_i[0]);
      for (int j = 0; j < 3; j++) begin
        t1_pu_q[j] <= $signed(u_i[j]) * $signed(pos_i[j]);
        t1_pw_q[j] <= $signed(w_i[j]) * $signed(pos_i[j]);
      end
      t1_u_q   <= u_i;
      t1_w_q   <= w_i;
      t1_pos_q <= pos_i;

      t2_vd_q[0] <= t1_vp_q[0] - t1_vp_q[1];
      t2_vd_q[1] <= t1_vp_q[2] - t1_vp_q[3];
      t2_vd_q[2] <= t1_vp_q[4] - t1_vp_q[5];
      t2_su_q    <= t1_pu_q[0] + t1_pu_q[1] + t1_pu_q[2];
      t2_sw_q    <= t1_pw_q[0] + t1_pw_q[1] + t1_pw_q[2];
      t2_u_q     <= t1_u_q;
      t2_w_q     <= t1_w_q;
      t2_pos_q   <= t1_pos_q;

      for (int j = 0; j < 3; j++) begin
        t3_v_q[j] <= clamp_axis(t2_vd_q[j]);
      end
      t3_ou_q  <= neg_sat(t2_su_q);
      t3_ow_q  <= neg_sat(t2_sw_q);
      t3_u_q   <= t2_u_q;
      t3_w_q   <= t2_w_q;
      t3_pos_q <= t2_pos_q;

      for (int j = 0; j < 3; j++) begin
        t4_pv_q[j] <= $signed(t3_v_q[j]) * $signed(t3_pos_q[j]);
      end
      t4_u_q  <= t3_u_q;
      t4_v_q  <= t3_v_q;
      t4_w_q  <= t3_w_q;
      t4_ou_q <= t3_ou_q;
      t4_ow_q <= t3_ow_q;

      t5_sv_q <= t4_pv_q[0] + t4_pv_q[1] + t4_pv_q[2];
      t5_u_q  <= t4_u_q;
      t5_v_q  <= t4_v_q;
      t5_w_q  <= t4_w_q;
      t5_ou_q <= t4_ou_q;
      t5_ow_q <= t4_ow_q;

      t6_ov_q <= neg_sat(t5_sv_q);
      t6_u_q  <= t5_u_q;
      t6_v_q  <= t5_v_q;
      t6_w_q  <= t5_w_q;
      t6_ou_q <= t5_ou_q;
      t6_ow_q <= t5_ow_q;
    end
  end

  assign ctl_o.valid = v_q[5];
  assign ctl_o.ok    = ok_q[5];
  assign u_o         = t6_u_q;
  assign v_o         = t6_v_q;
  assign w_o         = t6_w_q;
  assign off_o       = {t6_ow_q, t6_ov_q, t6_ou_q};

endmodule

`default_nettype wire

/* hdl/look_at_view_matrix_core.sv */
// Top level of the fixed-point look-at view matrix core.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i / in_stall_o | command, pos_*, vec_*, up_*
//  out     | out | out_valid_o / out_stall_i | row_index, axis_*, offset, degenerate, last
//
// One request per cycle enters while the pipeline flows; each request passes two 71-stage
// normalizers, each with a 32-stage root and 31-stage divider. Each request yields three
// rows, one per cycle unless out_stall_i is high, through a single output register bank;
// the bank takes a new request only when empty or as its last row leaves; until then a waiting
// result freezes the whole pipeline. Reset clears only valid bits and the row counter.
`default_nettype none

module look_at_view_matrix_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] up_x_i,
  input  logic signed [31:0] up_y_i,
  input  logic signed [31:0] up_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] axis_x_o,
  output logic signed [31:0] axis_y_o,
  output logic signed [31:0] axis_z_o,
  output logic signed [31:0] offset_o,
  output logic               degenerate_o,
  output logic               last_o
);
  import lav_pkg::*;

  logic en;

  // input stage: direction
  logic             s0_v_q;
  logic [2:0][32:0] s0_d_q;
  logic [2:0][31:0] s0_pos_q;
  logic [2:0][31:0] s0_up_q;
  logic [2:0][31:0] pos_in;
  logic [2:0][31:0] vec_in;
  logic [2:0][32:0] s0_d_d;

  assign pos_in = {pos_z_i, pos_y_i, pos_x_i};
  assign vec_in = {vec_z_i, vec_y_i, vec_x_i};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s0_d_d[j] = command_i ? {vec_in[j][31], vec_in[j]} - {pos_in[j][31], pos_in[j]}
                            : {vec_in[j][31], vec_in[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_d_q   <= s0_d_d;
      s0_pos_q <= pos_in;
      s0_up_q  <= {up_z_i, up_y_i, up_x_i};
    end
  end

  // w = normalize(direction)
  lav_ctl_t         n1_ctl;
  logic [2:0][31:0] n1_w;
  logic [191:0]     n1_side;

  lav_norm #(.IW(33), .SW(192)) u_norm_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .vec_i   (s0_d_q),
    .side_i  ({s0_up_q, s0_pos_q}),
    .ctl_o   (n1_ctl),
    .vec_o   (n1_w),
    .side_o  (n1_side)
  );

  logic [2:0][31:0] n1_up;
  logic [2:0][31:0] n1_pos;
  assign {n1_up, n1_pos} = n1_side;

  // w x up
  logic               x1_v_q, x2_v_q;
  logic               x1_ok_q, x2_ok_q;
  logic signed [63:0] x1_p_q [6];
  logic [2:0][31:0]   x1_w_q, x1_pos_q, x2_w_q, x2_pos_q;
  logic [2:0][63:0]   x2_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q <= 1'b0;
      x2_v_q <= 1'b0;
    end else if (en) begin
      x1_v_q <= n1_ctl.valid;
      x2_v_q <= x1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_p_q[0] <= $signed(n1_w[1]) * $signed(n1_up[2]);
      x1_p_q[1] <= $signed(n1_w[2]) * $signed(n1_up[1]);
      x1_p_q[2] <= $signed(n1_w[2]) * $signed(n1_up[0]);
      x1_p_q[3] <= $signed(n1_w[0]) * $signed(n1_up[2]);
      x1_p_q[4] <= $signed(n1_w[0]) * $signed(n1_up[1]);
      x1_p_q[5] <= $signed(n1_w[1]) * $signed(n1_up[0]);
      x1_ok_q   <= n1_ctl.ok;
      x1_w_q    <= n1_w;
      x1_pos_q  <= n1_pos;

      x2_c_q[0] <= x1_p_q[0] - x1_p_q[1];
      x2_c_q[1] <= x1_p_q[2] - x1_p_q[3];
      x2_c_q[2] <= x1_p_q[4] - x1_p_q[5];
      x2_ok_q   <= x1_ok_q;
      x2_w_q    <= x1_w_q;
      x2_pos_q  <= x1_pos_q;
    end
  end

  // u = normalize(w x up)
  lav_ctl_t         n2_ctl;
  logic [2:0][31:0] n2_u;
  logic [192:0]     n2_side;

  lav_norm #(.IW(64), .SW(193)) u_norm_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x2_v_q),
    .vec_i   (x2_c_q),
    .side_i  ({x2_ok_q, x2_w_q, x2_pos_q}),
    .ctl_o   (n2_ctl),
    .vec_o   (n2_u),
    .side_o  (n2_side)
  );

  logic             n2_ok_w;
  logic [2:0][31:0] n2_w;
  logic [2:0][31:0] n2_pos;
  lav_ctl_t         post_in;

  assign {n2_ok_w, n2_w, n2_pos} = n2_side;
  assign post_in.valid = n2_ctl.valid;
  assign post_in.ok    = n2_ctl.ok & n2_ok_w;

  lav_ctl_t         pp_ctl;
  logic [2:0][31:0] pp_u, pp_v, pp_w, pp_off;

  lav_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (post_in),
    .w_i    (n2_w),
    .u_i    (n2_u),
    .pos_i  (n2_pos),
    .ctl_o  (pp_ctl),
    .u_o    (pp_u),
    .v_o    (pp_v),
    .w_o    (pp_w),
    .off_o  (pp_off)
  );

  // output bank: three rows sent one per cycle while out_stall_i is low
  logic             ob_v_q, ob_v_d;
  row_e             ob_row_q, ob_row_d;
  logic             ob_deg_q;
  logic [2:0][31:0] ob_axis_q [3];
  logic [2:0][31:0] ob_off_q;
  logic             fire;
  logic             take_new;
  logic             load;

  assign fire     = ob_v_q & !out_stall_i;
  assign take_new = !ob_v_q || (fire && ob_row_q == ROW_W);
  assign en       = take_new || !pp_ctl.valid;
  assign load     = take_new && pp_ctl.valid;
  assign in_stall_o = !en;

  always_comb begin
    ob_v_d   = ob_v_q;
    ob_row_d = ob_row_q;
    if (load) begin
      ob_v_d   = 1'b1;
      ob_row_d = ROW_U;
    end else if (fire) begin
      unique case (ob_row_q)
        ROW_U:   ob_row_d = ROW_V;
        ROW_V:   ob_row_d = ROW_W;
        ROW_W:   ob_v_d   = 1'b0;
        default: ob_v_d   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q   <= 1'b0;
      ob_row_q <= ROW_U;
    end else begin
      ob_v_q   <= ob_v_d;
      ob_row_q <= ob_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_deg_q     <= !pp_ctl.ok;
      ob_axis_q[0] <= pp_ctl.ok ? pp_u : '0;
      ob_axis_q[1] <= pp_ctl.ok ? pp_v : '0;
      ob_axis_q[2] <= pp_ctl.ok ? pp_w : '0;
      ob_off_q     <= pp_ctl.ok ? pp_off : '0;
    end
  end

  logic [2:0][31:0] sel_axis;
  logic [31:0]      sel_off;

  always_comb begin
    unique case (ob_row_q)
      ROW_U: begin
        sel_axis = ob_axis_q[0];
        sel_off  = ob_off_q[0];
      end
      ROW_V: begin
        sel_axis = ob_axis_q[1];
        sel_off  = ob_off_q[1];
      end
      ROW_W: begin
        sel_axis = ob_axis_q[2];
        sel_off  = ob_off_q[2];
      end
      default: begin
        sel_axis = '0;
        sel_off  = '0;
      end
    endcase
  end

  assign out_valid_o  = ob_v_q;
  assign row_index_o  = ob_row_q;
  assign axis_x_o     = sel_axis[0];
  assign axis_y_o     = sel_axis[1];
  assign axis_z_o     = sel_axis[2];
  assign offset_o     = sel_off;
  assign degenerate_o = ob_deg_q;
  assign last_o       = (ob_row_q == ROW_W);

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      axis_x_o == 32'sd0 && axis_y_o == 32'sd0 && axis_z_o == 32'sd0 && offset_o == 32'sd0)
    else $error("degenerate row carries nonzero data");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      axis_x_o <= AxisOne && axis_x_o >= AxisNegOne &&
      axis_y_o <= AxisOne && axis_y_o >= AxisNegOne &&
      axis_z_o <= AxisOne && axis_z_o >= AxisNegOne)
    else $error("axis component out of unit range");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ob_row_q != ROW_W |=> ob_v_q && ob_row_q == row_e'($past(ob_row_q) + 2'd1))
    else $error("row sequence broken");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_v_q && !fire |=> ob_v_q && $stable(ob_row_q))
    else $error("pending row lost under stall");

endmodule

`default_nettype wire
